// ===== rtl/gbp_pkg.sv =====
// Shared types and constants for the uniform grid broad phase.
`default_nettype none
package gbp_pkg;

  localparam int ID_W        = 10;
  localparam int POS_W       = 24;
  localparam int LEN_W       = 23;
  localparam int DIM_W       = 7;
  localparam int DIM_MAX     = 64;
  localparam int CELL_W      = 6;
  localparam int CELL_ADDR_W = 12;
  localparam int MAX_CELLS   = 4096;
  localparam int CELL_SLOTS  = 8;
  localparam int SLOT_W      = 3;
  localparam int FILL_W      = 4;
  localparam int SLOT_ADDR_W = CELL_ADDR_W + SLOT_W;
  localparam int NB_MAX      = 32;
  localparam int NB_IDX_W    = 5;
  localparam int NB_CNT_W    = 6;
  localparam int NUM_W       = 27;
  localparam int QUO_W       = 7;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_W  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_H  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CELL_SZ = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HALF_W  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_HALF_H  = 3'd4;

  typedef struct packed {
    logic                   fill_rd;
    logic                   fill_we;
    logic [CELL_ADDR_W-1:0] fill_addr;
    logic [FILL_W-1:0]      fill_wdata;
    logic                   slot_rd;
    logic                   slot_we;
    logic [SLOT_ADDR_W-1:0] slot_addr;
    logic [ID_W-1:0]        slot_wdata;
  } store_req_t;

  function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_W'(DIM_MAX)) return DIM_W'(DIM_MAX);
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gbp_div.sv =====
// Iterative restoring divider giving a saturating 7-bit cell number.
`default_nettype none
module gbp_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [gbp_pkg::NUM_W-1:0]   num,
  input  wire logic [gbp_pkg::LEN_W-1:0]   den,
  output logic                             done,
  output logic [gbp_pkg::QUO_W-1:0]        quo
);
  import gbp_pkg::*;

  logic                  busy_r, done_r;
  logic [2:0]            step_r;
  logic [NUM_W-2:0]      rem_r;
  logic [LEN_W-1:0]      den_r;
  logic [QUO_W-1:0]      q_r;
  logic [NUM_W+1:0]      sh;

  assign sh   = (NUM_W+2)'(den_r) << step_r;
  assign done = done_r;
  assign quo  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == 3'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num[NUM_W-1] ? '0 : num[NUM_W-2:0];
      den_r  <= den;
      step_r <= 3'(QUO_W - 1);
      q_r    <= '0;
    end else if (busy_r) begin
      if ({3'b000, rem_r} >= sh) begin
        rem_r     <= rem_r - sh[NUM_W-2:0];
        q_r[step_r] <= 1'b1;
      end
      step_r <= step_r - 3'd1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gbp_store.sv =====
// Cell fill counters and cell slot memory, with registered read outputs.
`default_nettype none
module gbp_store (
  input  wire logic                       clk,
  input  wire gbp_pkg::store_req_t        req,
  output logic [gbp_pkg::FILL_W-1:0]      fill_q,
  output logic [gbp_pkg::ID_W-1:0]        slot_q
);
  import gbp_pkg::*;

  logic [FILL_W-1:0] fill_mem [MAX_CELLS];
  logic [ID_W-1:0]   slot_mem [MAX_CELLS*CELL_SLOTS];

  always_ff @(posedge clk) begin
    if (req.fill_we) fill_mem[req.fill_addr] <= req.fill_wdata;
    if (req.fill_rd) fill_q <= fill_mem[req.fill_addr];
  end

  always_ff @(posedge clk) begin
    if (req.slot_we) slot_mem[req.slot_addr] <= req.slot_wdata;
    if (req.slot_rd) slot_q <= slot_mem[req.slot_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/gbp_seen.sv =====
// Neighbor list of the running query with duplicate lookup.
`default_nettype none
module gbp_seen (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          clear,
  input  wire logic                          append,
  input  wire logic [gbp_pkg::ID_W-1:0]      probe_id,
  input  wire logic [gbp_pkg::NB_IDX_W-1:0]  rd_idx,
  output logic                               hit,
  output logic                               full,
  output logic [gbp_pkg::NB_CNT_W-1:0]       count,
  output logic [gbp_pkg::ID_W-1:0]           rd_id
);
  import gbp_pkg::*;

  logic [ID_W-1:0]     ids_r [NB_MAX];
  logic [NB_CNT_W-1:0] count_r;

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < NB_MAX; k++) begin
      if (NB_CNT_W'(k) < count_r && ids_r[k] == probe_id) hit = 1'b1;
    end
  end

  assign full  = (count_r == NB_CNT_W'(NB_MAX));
  assign count = count_r;
  assign rd_id = ids_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (clear) begin
      count_r <= '0;
    end else if (append) begin
      count_r <= count_r + NB_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (append && !clear) ids_r[count_r[NB_IDX_W-1:0]] <= probe_id;
  end

endmodule
`default_nettype wire

// ===== rtl/uniform_grid_broad_phase.sv =====
// Top level: control sequencer, configuration registers and result register.
`default_nettype none
// Uniform-grid broad phase for circles. One item is taken at a time. A clear
// sweeps the 4096 cell counters, one per cycle; the same sweep runs after
// reset before the first item is taken. Insert and query each run four
// cell-range divisions on a shared 7-step divider, then read the counter of
// each covered cell, with a write-back on insert; a query then reads each
// stored slot of a cell from the slot memory and hands out one result per
// cycle, while the output is ready, from its neighbor list.
module uniform_grid_broad_phase (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,   // object_id, pos_x, pos_y, radius
  input  wire logic [1:0]  in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // neighbor_id, has_neighbor, overflow
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [gbp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [gbp_pkg::LEN_W-1:0]      cfg_wdata
);
  import gbp_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_DIV_GO   = 10'b0000000100,
    S_DIV_WAIT = 10'b0000001000,
    S_CELL_RD  = 10'b0000010000,
    S_CELL_CHK = 10'b0000100000,
    S_SLOT_RD  = 10'b0001000000,
    S_SLOT_CHK = 10'b0010000000,
    S_EMIT     = 10'b0100000000,
    S_RESP     = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0] grid_w_r, grid_h_r;
  logic [LEN_W-1:0] cell_sz_r, half_w_r, half_h_r;

  logic [1:0]        op_r;
  logic [ID_W-1:0]   id_r;
  logic [POS_W-1:0]  px_r, py_r;
  logic [LEN_W-1:0]  rad_r;

  logic [1:0]              div_idx_r;
  logic [CELL_W-1:0]       x0_r, x1_r, y0_r, y1_r, x_r, y_r;
  logic [CELL_ADDR_W-1:0]  c_r, clr_addr_r;
  logic [FILL_W-1:0]       fill_r;
  logic [FILL_W-1:0]       slot_r;
  logic [NB_IDX_W-1:0]     k_r;
  logic                    ovf_r, clr_resp_r;

  logic        out_valid_r;
  logic [11:0] out_data_r;
  logic        out_last_r;

  logic [DIM_W-1:0]     gw, gh, dim_m1;
  logic [LEN_W-1:0]     cs;
  logic [POS_W-1:0]     r_eff;
  logic [NUM_W-1:0]     p_ext, r_ext, h_ext, num;
  logic                 div_done;
  logic [QUO_W-1:0]     quo;
  logic [CELL_W-1:0]    cell_q;
  logic [12:0]          prod;
  logic [CELL_ADDR_W-1:0] c_now;
  store_req_t           req;
  logic [FILL_W-1:0]    fill_q;
  logic [ID_W-1:0]      slot_q;
  logic                 seen_clear, seen_append, seen_hit, seen_full;
  logic [NB_CNT_W-1:0]  seen_count;
  logic [ID_W-1:0]      seen_rd;
  logic                 in_xfer, out_free, walk_end, fresh, emit_last;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_data_r};
  assign out_tlast  = out_last_r;

  assign gw     = dim_eff(grid_w_r);
  assign gh     = dim_eff(grid_h_r);
  assign cs     = (cell_sz_r == '0) ? LEN_W'(1) : cell_sz_r;
  assign dim_m1 = (div_idx_r[1] ? gh : gw) - DIM_W'(1);
  assign cell_q = (quo > dim_m1) ? dim_m1[CELL_W-1:0] : quo[CELL_W-1:0];

  assign r_eff = (op_r == OP_QUERY) ? ({1'b0, rad_r} + {1'b0, cs}) : {1'b0, rad_r};
  assign p_ext = div_idx_r[1] ? {{3{py_r[POS_W-1]}}, py_r} : {{3{px_r[POS_W-1]}}, px_r};
  assign r_ext = NUM_W'(r_eff);
  assign h_ext = NUM_W'(div_idx_r[1] ? half_h_r : half_w_r);
  assign num   = div_idx_r[0] ? (p_ext + r_ext + h_ext) : (p_ext - r_ext + h_ext);

  assign prod  = 13'(y_r) * 13'(gw);
  assign c_now = prod[CELL_ADDR_W-1:0] + CELL_ADDR_W'(x_r);

  assign walk_end  = (x_r == x1_r) && (y_r == y1_r);
  assign fresh     = (slot_q != id_r) && !seen_hit;
  assign emit_last = ({1'b0, k_r} == seen_count - NB_CNT_W'(1));

  gbp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIV_GO),
    .num   (num),
    .den   (cs),
    .done  (div_done),
    .quo   (quo)
  );

  gbp_store u_store (
    .clk    (clk),
    .req    (req),
    .fill_q (fill_q),
    .slot_q (slot_q)
  );

  assign seen_clear  = in_xfer;
  assign seen_append = (state_r == S_SLOT_CHK) && fresh && !seen_full;

  gbp_seen u_seen (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (seen_clear),
    .append   (seen_append),
    .probe_id (slot_q),
    .rd_idx   (k_r),
    .hit      (seen_hit),
    .full     (seen_full),
    .count    (seen_count),
    .rd_id    (seen_rd)
  );

  always_comb begin
    req            = '0;
    req.slot_wdata = id_r;
    unique case (state_r)
      S_CLEAR: begin
        req.fill_we   = 1'b1;
        req.fill_addr = clr_addr_r;
      end
      S_CELL_RD: begin
        req.fill_rd   = 1'b1;
        req.fill_addr = c_now;
      end
      S_CELL_CHK: begin
        req.fill_addr  = c_r;
        req.fill_wdata = fill_q + FILL_W'(1);
        req.slot_addr  = {c_r, fill_q[SLOT_W-1:0]};
        if (op_r == OP_INSERT && fill_q < FILL_W'(CELL_SLOTS)) begin
          req.fill_we = 1'b1;
          req.slot_we = 1'b1;
        end
      end
      S_SLOT_RD: begin
        req.slot_rd   = 1'b1;
        req.slot_addr = {c_r, slot_r[SLOT_W-1:0]};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:
        if (clr_addr_r == CELL_ADDR_W'(MAX_CELLS - 1))
          state_nxt = clr_resp_r ? S_RESP : S_IDLE;
      S_IDLE:
        if (in_xfer) begin
          unique case (in_tuser)
            OP_CLEAR:            state_nxt = S_CLEAR;
            OP_INSERT, OP_QUERY: state_nxt = S_DIV_GO;
            default:             state_nxt = S_RESP;
          endcase
        end
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT:
        if (div_done) state_nxt = (div_idx_r == 2'd3) ? S_CELL_RD : S_DIV_GO;
      S_CELL_RD:  state_nxt = S_CELL_CHK;
      S_CELL_CHK:
        if (op_r == OP_QUERY && fill_q != '0) state_nxt = S_SLOT_RD;
        else if (!walk_end) state_nxt = S_CELL_RD;
        else if (op_r == OP_QUERY && seen_count != '0) state_nxt = S_EMIT;
        else state_nxt = S_RESP;
      S_SLOT_RD:  state_nxt = S_SLOT_CHK;
      S_SLOT_CHK:
        if (fresh && seen_full) state_nxt = S_EMIT;
        else if (slot_r + FILL_W'(1) != fill_r) state_nxt = S_SLOT_RD;
        else if (!walk_end) state_nxt = S_CELL_RD;
        else if (seen_count != '0 || seen_append) state_nxt = S_EMIT;
        else state_nxt = S_RESP;
      S_EMIT:
        if (out_free && emit_last) state_nxt = S_IDLE;
      S_RESP:
        if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_resp_r <= 1'b0;
      clr_addr_r <= '0;
      ovf_r      <= 1'b0;
      out_valid_r <= 1'b0;
      grid_w_r   <= DIM_W'(64);
      grid_h_r   <= DIM_W'(64);
      cell_sz_r  <= LEN_W'(256);
      half_w_r   <= LEN_W'(8192);
      half_h_r   <= LEN_W'(8192);
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_GRID_W:  grid_w_r  <= cfg_wdata[DIM_W-1:0];
          REG_GRID_H:  grid_h_r  <= cfg_wdata[DIM_W-1:0];
          REG_CELL_SZ: cell_sz_r <= cfg_wdata;
          REG_HALF_W:  half_w_r  <= cfg_wdata;
          REG_HALF_H:  half_h_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_CLEAR) clr_addr_r <= clr_addr_r + CELL_ADDR_W'(1);
      if (in_xfer) begin
        ovf_r      <= 1'b0;
        clr_resp_r <= 1'b1;
        clr_addr_r <= '0;
      end
      if (state_r == S_CELL_CHK && op_r == OP_INSERT && fill_q >= FILL_W'(CELL_SLOTS))
        ovf_r <= 1'b1;
      if (state_r == S_SLOT_CHK && fresh && seen_full) ovf_r <= 1'b1;
      if ((state_r == S_EMIT || state_r == S_RESP) && out_free)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r      <= in_tuser;
      id_r      <= in_tdata[9:0];
      px_r      <= in_tdata[33:10];
      py_r      <= in_tdata[57:34];
      rad_r     <= in_tdata[80:58];
      div_idx_r <= 2'd0;
      k_r       <= '0;
    end
    if (state_r == S_DIV_WAIT && div_done) begin
      unique case (div_idx_r)
        2'd0: x0_r <= cell_q;
        2'd1: x1_r <= cell_q;
        2'd2: y0_r <= cell_q;
        2'd3: begin
          y1_r <= cell_q;
          x_r  <= x0_r;
          y_r  <= y0_r;
        end
      endcase
      div_idx_r <= div_idx_r + 2'd1;
    end
    if (state_r == S_CELL_RD) c_r <= c_now;
    if (state_r == S_CELL_CHK) begin
      fill_r <= fill_q;
      slot_r <= '0;
    end
    if (state_r == S_SLOT_CHK) slot_r <= slot_r + FILL_W'(1);
    if ((state_r == S_CELL_CHK && !(op_r == OP_QUERY && fill_q != '0)) ||
        (state_r == S_SLOT_CHK && slot_r + FILL_W'(1) == fill_r)) begin
      if (x_r == x1_r) begin
        x_r <= x0_r;
        y_r <= y_r + CELL_W'(1);
      end else begin
        x_r <= x_r + CELL_W'(1);
      end
    end
    if (state_r == S_EMIT && out_free) begin
      out_data_r <= {emit_last && ovf_r, 1'b1, seen_rd};
      out_last_r <= emit_last;
      k_r        <= k_r + NB_IDX_W'(1);
    end
    if (state_r == S_RESP && out_free) begin
      out_data_r <= {(op_r == OP_INSERT) && ovf_r, 1'b0, {ID_W{1'b0}}};
      out_last_r <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_count <= NB_CNT_W'(NB_MAX))
    else $error("neighbor list count beyond limit");

  a_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
    req.fill_we && req.slot_we |-> req.fill_addr == req.slot_addr[SLOT_ADDR_W-1:SLOT_W])
    else $error("fill and slot writes address different cells");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV_WAIT)
    else $error("divider finished outside its wait state");
`endif

endmodule
`default_nettype wire
